// ===== rtl/core/gnze_pkg.sv =====
package gnze_pkg;

  // Field widths
  localparam int ZONE_W       = 32;
  localparam int GRID_SIDE_W  = 16;
  localparam int SIDE_BITS    = 16;
  localparam int REACH_W      = 2;
  localparam int MAX_REACH    = 3;
  localparam int TOT_W        = 2 * SIDE_BITS;
  localparam int DIV_CNT_W    = $clog2(ZONE_W);

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ENABLED = 2'd0,
    CFG_BASE_ZONE    = 2'd1,
    CFG_GRID_SIDE    = 2'd2,
    CFG_REACH        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                   grid_enabled;
    logic [ZONE_W-1:0]      base_zone;
    logic [GRID_SIDE_W-1:0] grid_side;
    logic [REACH_W-1:0]     reach;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/gnze_if.sv =====
interface gnze_in_if;
  logic                       valid;
  logic                       ready;
  logic [gnze_pkg::ZONE_W-1:0] current_zone;

  modport source (output valid, output current_zone, input ready);
  modport sink   (input valid, input current_zone, output ready);
endinterface

interface gnze_out_if;
  logic                       valid;
  logic                       ready;
  logic [gnze_pkg::ZONE_W-1:0] neighbour_zone;
  logic                       last_one;

  modport source (output valid, output neighbour_zone, output last_one, input ready);
  modport sink   (input valid, input neighbour_zone, input last_one, output ready);
endinterface

// ===== rtl/core/grid_neighbour_zone_enumerator.sv =====
// Grid neighbour zone enumerator.
// Input channel in_chan carries one current_zone per transfer. If the grid
// rule is enabled and the zone lies on the configured square grid, the block
// emits on out_chan every zone of the clipped window of radius reach around
// it, row-major, with last_one set on the final one. Off-grid zones, a zero
// grid side or a disabled rule give no results.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0 enable,
// 1 base zone, 2 grid side, 3 reach); write only while idle.
// Timing: one item at a time; in_chan.ready is high only when idle. After a
// transfer the block runs range checks (CHECK, CMP), then the shared
// bit-serial divider (32 steps for row and column, then a hand-off), then
// window setup (SETUP, START) before the first result shows. The window
// then streams at one result per cycle while out_chan.ready is high (up to
// 49), and ready returns the cycle after the last result transfers. A rejected
// zone brings ready back once its range checks are done.
// A stalled receiver holds the current result in the output register.
// Reset (rst_n low, synchronous) empties the block and restores register
// defaults: rule off, base 0, side 1, reach 0.
module grid_neighbour_zone_enumerator (
  input  logic                             clk,
  input  logic                             rst_n,
  gnze_in_if.sink                          in_chan,
  gnze_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [gnze_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [gnze_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ZW = gnze_pkg::ZONE_W;
  localparam int SB = gnze_pkg::SIDE_BITS;
  localparam int RW = gnze_pkg::REACH_W;
  localparam int TW = gnze_pkg::TOT_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_CMP   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_SETUP = 7'b0010000,
    ST_START = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  gnze_pkg::cfg_t      cfg;
  gnze_pkg::div_stat_t div_stat;
  logic                div_start;
  logic [SB-1:0]       row, col;
  logic [SB-1:0]       side;

  logic [ZW-1:0]       zone_r;
  logic [ZW-1:0]       linear_r;
  logic [TW-1:0]       total_r;
  logic                ok_r;
  logic [SB-1:0]       r_r, c_r, clo_r, rhi_r, chi_r;
  logic [RW-1:0]       dc_r;
  logic [RW+SB-1:0]    dr_side_r;
  logic [ZW-1:0]       z_r, row_start_r;

  logic [ZW:0]         zdiff;
  logic [RW-1:0]       rad;
  logic [SB-1:0]       rad_ext, side_m1;
  logic [SB-1:0]       rlo, rhi, clo, chi;
  logic [SB:0]         rsum, csum;
  logic [SB-1:0]       dr_full, dc_full;
  logic [ZW-1:0]       start_zone;
  logic                in_xfer, out_xfer, last, on_grid;

  gnze_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  gnze_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (linear_r),
    .divisor   (side),
    .quotient  (row),
    .remainder (col),
    .stat      (div_stat)
  );

  assign side = cfg.grid_side[SB-1:0];

  // Handshake
  assign in_chan.ready           = (state_r == ST_IDLE);
  assign in_xfer                 = in_chan.valid && in_chan.ready;
  assign out_chan.valid          = (state_r == ST_EMIT);
  assign out_chan.neighbour_zone = z_r;
  assign last                    = (r_r == rhi_r) && (c_r == chi_r);
  assign out_chan.last_one       = last;
  assign out_xfer                = out_chan.valid && out_chan.ready;

  // Offset from the base zone; top bit flags a zone below base
  assign zdiff   = {1'b0, zone_r} - {1'b0, cfg.base_zone};
  assign on_grid = ok_r && ({1'b0, linear_r} < {{(ZW + 1 - TW){1'b0}}, total_r});
  assign div_start = (state_r == ST_CMP) && on_grid;

  // Window bounds, clipped to the grid edges
  assign rad     = (cfg.reach > RW'(gnze_pkg::MAX_REACH)) ? RW'(gnze_pkg::MAX_REACH)
                                                          : cfg.reach;
  assign rad_ext = {{(SB - RW){1'b0}}, rad};
  assign side_m1 = side - 1'b1;
  assign rsum    = {1'b0, row} + {1'b0, rad_ext};
  assign csum    = {1'b0, col} + {1'b0, rad_ext};
  assign rlo     = (row >= rad_ext) ? row - rad_ext : '0;
  assign clo     = (col >= rad_ext) ? col - rad_ext : '0;
  assign rhi     = (rsum > {1'b0, side_m1}) ? side_m1 : rsum[SB-1:0];
  assign chi     = (csum > {1'b0, side_m1}) ? side_m1 : csum[SB-1:0];
  assign dr_full = row - rlo;
  assign dc_full = col - clo;

  // Zone of the window's top-left cell
  assign start_zone = zone_r - {{(ZW - RW - SB){1'b0}}, dr_side_r}
                             - {{(ZW - RW){1'b0}}, dc_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_CMP;
      ST_CMP:   state_nxt = on_grid ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_stat.done) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_START;
      ST_START: state_nxt = ST_EMIT;
      ST_EMIT:  if (out_xfer && last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) zone_r <= in_chan.current_zone;
      end
      ST_CHECK: begin
        linear_r <= zdiff[ZW-1:0];
        total_r  <= {{(TW - SB){1'b0}}, side} * {{(TW - SB){1'b0}}, side};
        ok_r     <= cfg.grid_enabled && (side != '0) && !zdiff[ZW];
      end
      ST_SETUP: begin
        r_r       <= rlo;
        c_r       <= clo;
        clo_r     <= clo;
        rhi_r     <= rhi;
        chi_r     <= chi;
        dc_r      <= dc_full[RW-1:0];
        dr_side_r <= {{SB{1'b0}}, dr_full[RW-1:0]} * {{RW{1'b0}}, side};
      end
      ST_START: begin
        z_r         <= start_zone;
        row_start_r <= start_zone;
      end
      ST_EMIT: begin
        // Advance along the row, wrap to the next row at its right edge
        if (out_xfer && !last) begin
          if (c_r == chi_r) begin
            c_r         <= clo_r;
            r_r         <= r_r + 1'b1;
            row_start_r <= row_start_r + {{(ZW - SB){1'b0}}, side};
            z_r         <= row_start_r + {{(ZW - SB){1'b0}}, side};
          end else begin
            c_r <= c_r + 1'b1;
            z_r <= z_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/gnze_cfg_regs.sv =====
module gnze_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gnze_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gnze_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gnze_pkg::cfg_t                    cfg
);

  gnze_pkg::cfg_t cfg_r;
  gnze_pkg::cfg_idx_t idx;

  assign idx = gnze_pkg::cfg_idx_t'(cfg_idx);
  assign cfg = cfg_r;

  // Write one register per transfer, masked to its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_enabled <= 1'b0;
      cfg_r.base_zone    <= '0;
      cfg_r.grid_side    <= gnze_pkg::GRID_SIDE_W'(1);
      cfg_r.reach        <= '0;
    end else if (cfg_we) begin
      case (idx)
        gnze_pkg::CFG_GRID_ENABLED: cfg_r.grid_enabled <= cfg_data[0];
        gnze_pkg::CFG_BASE_ZONE:    cfg_r.base_zone    <= cfg_data[gnze_pkg::ZONE_W-1:0];
        gnze_pkg::CFG_GRID_SIDE:    cfg_r.grid_side    <= cfg_data[gnze_pkg::GRID_SIDE_W-1:0];
        gnze_pkg::CFG_REACH:        cfg_r.reach        <= cfg_data[gnze_pkg::REACH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/gnze_div.sv =====
module gnze_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [gnze_pkg::ZONE_W-1:0]      dividend,
  input  logic [gnze_pkg::SIDE_BITS-1:0]   divisor,
  output logic [gnze_pkg::SIDE_BITS-1:0]   quotient,
  output logic [gnze_pkg::SIDE_BITS-1:0]   remainder,
  output gnze_pkg::div_stat_t              stat
);

  localparam int SB = gnze_pkg::SIDE_BITS;
  localparam int ZW = gnze_pkg::ZONE_W;

  logic [ZW-1:0]                   quo_r;
  logic [SB-1:0]                   rem_r;
  logic [gnze_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [SB:0]   trial;
  logic [SB:0]   diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[ZW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  assign quotient  = quo_r[SB-1:0];
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // Sequence one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == gnze_pkg::DIV_CNT_W'(ZW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the working registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[ZW-2:0], fits};
      rem_r <= fits ? diff[SB-1:0] : trial[SB-1:0];
    end
  end

endmodule

// ===== rtl/core/gnze_checker.sv =====
module gnze_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gnze_pkg::ZONE_W-1:0]   neighbour_zone,
  input logic                          last_one
);

  // One item at a time: a new input never overlaps pending results
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results are pending");

  // In the cycle after an input transfer the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("block not busy after input transfer");

  // A window streams without gaps until its last result
  a_window_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_one) |=> out_valid)
    else $error("gap inside a result window");

  // The last result ends the window
  a_window_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_one) |=> !out_valid)
    else $error("result shown after the last one");

  // Stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(neighbour_zone) && $stable(last_one)))
    else $error("stalled result changed");

endmodule

bind grid_neighbour_zone_enumerator gnze_checker u_gnze_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .neighbour_zone (out_chan.neighbour_zone),
  .last_one       (out_chan.last_one)
);
